// File: rtl/serial_register_coil_slave_top_macros.svh
// assertion macros for the serial register and coil slave
`ifndef SERIAL_REGISTER_COIL_SLAVE_TOP_MACROS_SVH
`define SERIAL_REGISTER_COIL_SLAVE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SRCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SRCS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SRCS_ASSERT(lbl, prop, msg)
`define SRCS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: rtl/srcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package srcs_pkg;

  localparam int NumRegsDef  = 96;
  localparam int NumCoilsDef = 96;

  localparam logic [15:0] TimeoutRst   = 16'd60000;
  localparam logic [7:0]  CheckSeedRst = 8'h55;
  localparam logic [2:0]  FrameBody    = 3'd6;

  // item opcodes
  localparam logic [2:0] OP_RX      = 3'd0;
  localparam logic [2:0] OP_TICK    = 3'd1;
  localparam logic [2:0] OP_TX      = 3'd2;
  localparam logic [2:0] OP_REG_WR  = 3'd3;
  localparam logic [2:0] OP_COIL_WR = 3'd4;
  localparam logic [2:0] OP_RD      = 3'd5;

  // frame function codes
  localparam logic [15:0] FN_READ    = 16'd1;
  localparam logic [15:0] FN_WR_COIL = 16'd5;
  localparam logic [15:0] FN_WR_REG  = 16'd6;

  // frame status
  localparam logic [1:0] ST_NONE      = 2'd0;
  localparam logic [1:0] ST_OK        = 2'd1;
  localparam logic [1:0] ST_BAD_CHECK = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_SEED    = 2'd1;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  rx_byte;
    logic [7:0]  local_index;
    logic [15:0] local_value;
  } item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        link_active;
    logic [1:0]  frame_status;
    logic [15:0] read_register;
    logic        read_coil;
  } result_t;

  // memory strobes from the front end
  typedef struct packed {
    logic reg_wr;
    logic reg_rd;
    logic coil_wr;
    logic coil_rd;
    logic coil_wbit;
  } mem_req_t;

  // what the second stage needs to finish an item
  typedef struct packed {
    logic       tx_valid;
    logic       tx_reg;
    logic       tx_lo;
    logic       tx_coil;
    logic       tx_last;
    logic       tx_first;
    logic       rd_reg;
    logic       rd_coil;
    logic [2:0] coil_bit;
    logic       link_active;
    logic [1:0] status;
  } stage_t;

endpackage
`default_nettype wire

// File: rtl/srcs_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface srcs_item_if import srcs_pkg::*; ;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srcs_result_if import srcs_pkg::*; ;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srcs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/serial_register_coil_slave_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Serial register and coil slave. Received bytes are gathered into seven-byte frames
// (function code, address, data, check byte); a good frame marks the link active and
// either queues a full dump of registers and coils (code 1), writes a coil (code 5) or
// writes a register (code 6). Each transmit slot item returns the next byte of a queued
// dump, ending with its check byte. Millisecond tick items age the link, and local items
// write and read the stores directly. Every item gives exactly one result. One item is
// taken per clock while the output register is not stalled: on acceptance the control
// stage updates the frame and link state and issues one access to the register memory
// and one to the coil memory; the result is then finished from the registered memory
// data into an output register. Only a stalled output register holds items back.
// Both memories start out reading as zero with no clearing pass after reset.
module serial_register_coil_slave_top import srcs_pkg::*; #(
  parameter int NUM_REGS  = NumRegsDef,
  parameter int NUM_COILS = NumCoilsDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  srcs_cfg_if.sink      cfg_i,
  srcs_item_if.sink     item_i,
  srcs_result_if.source result_o
);

  localparam int CoilBytes = (NUM_COILS + 7) / 8;
  localparam int CheckPos  = 2 * NUM_REGS + CoilBytes;
  localparam int RaW       = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int CiW       = $clog2(NUM_COILS);
  localparam int CrW       = (CoilBytes > 1) ? $clog2(CoilBytes) : 1;
  localparam int RiW       = $clog2(CheckPos + 1);

  logic           accept, adv;
  logic           s1_vld_q;
  logic           out_vld_q;
  result_t        out_q, res_d;
  mem_req_t       req;
  stage_t         stage;
  logic [RaW-1:0] reg_waddr, reg_raddr;
  logic [15:0]    reg_wdata, reg_rdata;
  logic [CiW-1:0] coil_waddr;
  logic [CrW-1:0] coil_raddr;
  logic [7:0]     coil_rdata;
  logic [7:0]     seed;
  logic [7:0]     tx_chk_q, tx_chk_d;
  logic [7:0]     tx_b;

  assign adv          = s1_vld_q && (!out_vld_q || result_o.ready);
  assign item_i.ready = !s1_vld_q || adv;
  assign accept       = item_i.valid && item_i.ready;

  srcs_ctl #(
    .NUM_REGS  (NUM_REGS),
    .NUM_COILS (NUM_COILS),
    .RA_W      (RaW),
    .CI_W      (CiW),
    .CR_W      (CrW),
    .CHECK_POS (CheckPos),
    .RI_W      (RiW)
  ) u_ctl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .accept_i     (accept),
    .item_i       (item_i.data),
    .req_o        (req),
    .reg_waddr_o  (reg_waddr),
    .reg_wdata_o  (reg_wdata),
    .reg_raddr_o  (reg_raddr),
    .coil_waddr_o (coil_waddr),
    .coil_raddr_o (coil_raddr),
    .stage_o      (stage),
    .seed_o       (seed)
  );

  srcs_reg_ram #(
    .NUM_REGS (NUM_REGS),
    .RA_W     (RaW)
  ) u_reg_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (req.reg_wr),
    .waddr_i (reg_waddr),
    .wdata_i (reg_wdata),
    .rd_i    (req.reg_rd),
    .raddr_i (reg_raddr),
    .rdata_o (reg_rdata)
  );

  srcs_coil_ram #(
    .NUM_COILS  (NUM_COILS),
    .COIL_BYTES (CoilBytes),
    .CI_W       (CiW),
    .CR_W       (CrW)
  ) u_coil_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (req.coil_wr),
    .waddr_i (coil_waddr),
    .wbit_i  (req.coil_wbit),
    .rd_i    (req.coil_rd),
    .raddr_i (coil_raddr),
    .rdata_o (coil_rdata)
  );

  always_comb begin
    priority if (stage.tx_reg) begin
      tx_b = stage.tx_lo ? reg_rdata[7:0] : reg_rdata[15:8];
    end else if (stage.tx_coil) begin
      tx_b = coil_rdata;
    end else begin
      tx_b = tx_chk_q;
    end

    tx_chk_d = tx_chk_q;
    if (adv && stage.tx_valid && !stage.tx_last) begin
      tx_chk_d = (stage.tx_first ? seed : tx_chk_q) ^ tx_b;
    end

    res_d               = '0;
    res_d.tx_valid      = stage.tx_valid;
    res_d.tx_byte       = stage.tx_valid ? tx_b : 8'd0;
    res_d.tx_last       = stage.tx_last;
    res_d.link_active   = stage.link_active;
    res_d.frame_status  = stage.status;
    res_d.read_register = stage.rd_reg ? reg_rdata : 16'd0;
    res_d.read_coil     = stage.rd_coil ? coil_rdata[stage.coil_bit] : 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      tx_chk_q  <= CheckSeedRst;
    end else begin
      tx_chk_q <= tx_chk_d;
      if (accept) begin
        s1_vld_q <= 1'b1;
      end else if (adv) begin
        s1_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res_d;
    end
  end

  assign result_o.valid = out_vld_q;
  assign result_o.data  = out_q;

endmodule
`default_nettype wire

// File: rtl/srcs_reg_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module srcs_reg_ram import srcs_pkg::*; #(
  parameter int NUM_REGS = NumRegsDef,
  parameter int RA_W     = 7
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_i,
  input  wire logic [RA_W-1:0] waddr_i,
  input  wire logic [15:0]     wdata_i,
  input  wire logic            rd_i,
  input  wire logic [RA_W-1:0] raddr_i,
  output logic [15:0]          rdata_o
);

  logic [15:0]         mem [NUM_REGS];
  logic [15:0]         rdata_q;
  logic [NUM_REGS-1:0] vld_q;
  logic                rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (rd_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (rd_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : 16'd0;

endmodule
`default_nettype wire

// File: rtl/srcs_coil_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module srcs_coil_ram import srcs_pkg::*; #(
  parameter int NUM_COILS  = NumCoilsDef,
  parameter int COIL_BYTES = (NUM_COILS + 7) / 8,
  parameter int CI_W       = 7,
  parameter int CR_W       = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_i,
  input  wire logic [CI_W-1:0] waddr_i,
  input  wire logic            wbit_i,
  input  wire logic            rd_i,
  input  wire logic [CR_W-1:0] raddr_i,
  output logic [7:0]           rdata_o
);

  localparam int CoilPad = COIL_BYTES * 8;

  logic [7:0]         mem [COIL_BYTES];
  logic [7:0]         rdata_q;
  logic [7:0]         rmask_q;
  logic [CoilPad-1:0] vld_q;
  logic [CR_W-1:0]    wrow;

  assign wrow = CR_W'(waddr_i >> 3);

  // one row of eight coils, bit write enable
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem[wrow][waddr_i[2:0]] <= wbit_i;
    end
    if (rd_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rmask_q <= '0;
    end else begin
      if (wr_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (rd_i) begin
        rmask_q <= vld_q[raddr_i*8 +: 8];
      end
    end
  end

  assign rdata_o = rdata_q & rmask_q;

endmodule
`default_nettype wire

// File: rtl/srcs_ctl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "serial_register_coil_slave_top_macros.svh"
module srcs_ctl import srcs_pkg::*; #(
  parameter int NUM_REGS   = NumRegsDef,
  parameter int NUM_COILS  = NumCoilsDef,
  parameter int RA_W       = 7,
  parameter int CI_W       = 7,
  parameter int CR_W       = 4,
  parameter int CHECK_POS  = 204,
  parameter int RI_W       = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  srcs_cfg_if.sink             cfg_i,
  input  wire logic            accept_i,
  input  wire item_t           item_i,
  output mem_req_t             req_o,
  output logic [RA_W-1:0]      reg_waddr_o,
  output logic [15:0]          reg_wdata_o,
  output logic [RA_W-1:0]      reg_raddr_o,
  output logic [CI_W-1:0]      coil_waddr_o,
  output logic [CR_W-1:0]      coil_raddr_o,
  output stage_t               stage_o,
  output logic [7:0]           seed_o
);

  localparam logic [RI_W-1:0] TxRegEnd = RI_W'(2 * NUM_REGS);
  localparam logic [RI_W-1:0] TxChkPos = RI_W'(CHECK_POS);

  logic [15:0]     timeout_q;
  logic [7:0]      seed_q;
  logic [2:0]      pos_q, pos_d;
  logic [7:0]      rxchk_q, rxchk_d;
  logic [7:0]      fbuf_q [6];
  logic            active_q, active_d;
  logic [15:0]     idle_q, idle_d;
  logic            pend_q, pend_d;
  logic [RI_W-1:0] ridx_q, ridx_d;
  stage_t          stage_q, stage_d;
  logic [15:0]     code, addr, data, idle_inc;

  assign cfg_i.ready = 1'b1;
  assign seed_o      = seed_q;
  assign stage_o     = stage_q;

  assign code     = {fbuf_q[0], fbuf_q[1]};
  assign addr     = {fbuf_q[2], fbuf_q[3]};
  assign data     = {fbuf_q[4], fbuf_q[5]};
  assign idle_inc = (idle_q == 16'hffff) ? idle_q : idle_q + 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutRst;
      seed_q    <= CheckSeedRst;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_TIMEOUT) begin
        timeout_q <= cfg_i.data;
      end else if (cfg_i.index == CFG_SEED) begin
        seed_q <= cfg_i.data[7:0];
      end
    end
  end

  always_comb begin
    pos_d        = pos_q;
    rxchk_d      = rxchk_q;
    active_d     = active_q;
    idle_d       = idle_q;
    pend_d       = pend_q;
    ridx_d       = ridx_q;
    stage_d      = '0;
    req_o        = '0;
    reg_waddr_o  = '0;
    reg_wdata_o  = '0;
    reg_raddr_o  = '0;
    coil_waddr_o = '0;
    coil_raddr_o = '0;
    if (accept_i) begin
      unique case (item_i.op)
        OP_RX: begin
          if (pos_q < FrameBody) begin
            rxchk_d = ((pos_q == 3'd0) ? seed_q : rxchk_q) ^ item_i.rx_byte;
            pos_d   = pos_q + 3'd1;
          end else begin
            pos_d   = 3'd0;
            rxchk_d = seed_q;
            if (item_i.rx_byte != rxchk_q) begin
              stage_d.status = ST_BAD_CHECK;
            end else begin
              stage_d.status = ST_OK;
              active_d       = 1'b1;
              idle_d         = 16'd0;
              unique case (code)
                FN_READ: begin
                  pend_d = 1'b1;
                  ridx_d = '0;
                end
                FN_WR_COIL: begin
                  if (addr < 16'(NUM_COILS)) begin
                    req_o.coil_wr   = 1'b1;
                    req_o.coil_wbit = (data != 16'd0);
                    coil_waddr_o    = CI_W'(addr);
                  end else begin
                    stage_d.status = ST_RANGE;
                  end
                end
                FN_WR_REG: begin
                  if (addr < 16'(NUM_REGS)) begin
                    req_o.reg_wr = 1'b1;
                    reg_waddr_o  = RA_W'(addr);
                    reg_wdata_o  = data;
                  end else begin
                    stage_d.status = ST_RANGE;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        OP_TICK: begin
          idle_d = idle_inc;
          if (idle_inc > timeout_q) begin
            active_d = 1'b0;
          end
        end
        OP_TX: begin
          if (pend_q) begin
            stage_d.tx_valid = 1'b1;
            stage_d.tx_first = (ridx_q == '0);
            if (ridx_q < TxRegEnd) begin
              req_o.reg_rd     = 1'b1;
              reg_raddr_o      = RA_W'(ridx_q >> 1);
              stage_d.tx_reg   = 1'b1;
              stage_d.tx_lo    = ridx_q[0];
              ridx_d           = ridx_q + RI_W'(1);
            end else if (ridx_q < TxChkPos) begin
              req_o.coil_rd    = 1'b1;
              coil_raddr_o     = CR_W'(ridx_q - TxRegEnd);
              stage_d.tx_coil  = 1'b1;
              ridx_d           = ridx_q + RI_W'(1);
            end else begin
              stage_d.tx_last  = 1'b1;
              pend_d           = 1'b0;
              ridx_d           = '0;
            end
          end
        end
        OP_REG_WR: begin
          if (item_i.local_index < 8'(NUM_REGS)) begin
            req_o.reg_wr = 1'b1;
            reg_waddr_o  = RA_W'(item_i.local_index);
            reg_wdata_o  = item_i.local_value;
          end
        end
        OP_COIL_WR: begin
          if (item_i.local_index < 8'(NUM_COILS)) begin
            req_o.coil_wr   = 1'b1;
            req_o.coil_wbit = (item_i.local_value != 16'd0);
            coil_waddr_o    = CI_W'(item_i.local_index);
          end
        end
        OP_RD: begin
          if (item_i.local_index < 8'(NUM_REGS)) begin
            req_o.reg_rd   = 1'b1;
            reg_raddr_o    = RA_W'(item_i.local_index);
            stage_d.rd_reg = 1'b1;
          end
          if (item_i.local_index < 8'(NUM_COILS)) begin
            req_o.coil_rd    = 1'b1;
            coil_raddr_o     = CR_W'(item_i.local_index >> 3);
            stage_d.rd_coil  = 1'b1;
            stage_d.coil_bit = item_i.local_index[2:0];
          end
        end
        default: ;
      endcase
    end
    stage_d.link_active = active_d;
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && item_i.op == OP_RX && pos_q < FrameBody) begin
      fbuf_q[pos_q] <= item_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 3'd0;
      rxchk_q  <= CheckSeedRst;
      active_q <= 1'b0;
      idle_q   <= 16'd0;
      pend_q   <= 1'b0;
      ridx_q   <= '0;
      stage_q  <= '0;
    end else begin
      pos_q    <= pos_d;
      rxchk_q  <= rxchk_d;
      active_q <= active_d;
      idle_q   <= idle_d;
      pend_q   <= pend_d;
      ridx_q   <= ridx_d;
      if (accept_i) begin
        stage_q <= stage_d;
      end
    end
  end

  `SRCS_ASSERT(a_idx_idle, !pend_q |-> (ridx_q == '0), "response index moved while idle")
  `SRCS_ASSERT(a_idx_bound, pend_q |-> (ridx_q <= TxChkPos), "response index past check byte")
  `SRCS_ASSERT_RST(a_pos_bound, pos_q <= FrameBody, "frame position past frame body")
  `SRCS_ASSERT(a_timeout,
               (accept_i && item_i.op == OP_TICK && idle_q > timeout_q) |=> !active_q,
               "link still active after timeout")

endmodule
`default_nettype wire
